FILE: design/lecn_pkg.sv
// Shared types and codes for the capture leader election node.
// Used by lecn_front, lecn_back and leader_election_capture_node_top.
package lecn_pkg;

  localparam int ID_BITS   = 16;
  localparam int PORT_BITS = 8;
  localparam int LVL_BITS  = 8;
  localparam int MAX_PORTS = 255;

  // Incoming message opcodes.
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_CAPTURE = 3'd1;
  localparam logic [2:0] OP_ACCEPT  = 3'd2;
  localparam logic [2:0] OP_HELP    = 3'd3;
  localparam logic [2:0] OP_DEFEAT  = 3'd4;

  // Classified commands handed from the front to the back.
  localparam logic [2:0] CMD_NOP     = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_CAPTURE = 3'd2;
  localparam logic [2:0] CMD_ACCEPT  = 3'd3;
  localparam logic [2:0] CMD_HELP    = 3'd4;
  localparam logic [2:0] CMD_DEFEAT  = 3'd5;

  // Outgoing message kinds.
  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_HELP    = 3'd1;
  localparam logic [2:0] KIND_VICTORY = 3'd2;
  localparam logic [2:0] KIND_DEFEAT  = 3'd3;
  localparam logic [2:0] KIND_CAPTURE = 3'd4;

  // Node modes.
  localparam logic [1:0] MODE_PASSIVE   = 2'd0;
  localparam logic [1:0] MODE_CAPTURED  = 2'd1;
  localparam logic [1:0] MODE_CANDIDATE = 2'd2;

  // Configuration register indexes.
  localparam logic REG_NODE_ID         = 1'b0;
  localparam logic REG_NEIGHBOUR_COUNT = 1'b1;

  localparam int CMD_Q_DEPTH = 4;
  localparam int CMD_Q_AW    = 2;
  localparam int OUT_Q_DEPTH = 2;

  typedef struct packed {
    logic [2:0]           kind;
    logic [PORT_BITS-1:0] arrival_port;
    logic [LVL_BITS-1:0]  cand_level;
    logic [ID_BITS-1:0]   cand_id;
    logic [PORT_BITS-1:0] relay_port;
  } cmd_t;

  typedef struct packed {
    logic                 send_valid;
    logic [PORT_BITS-1:0] send_port;
    logic [2:0]           send_kind;
    logic [LVL_BITS-1:0]  send_level;
    logic [ID_BITS-1:0]   send_id;
    logic [PORT_BITS-1:0] send_relay;
    logic [1:0]           node_mode;
    logic                 is_leader;
  } res_t;

  // Handshake between the command queue and the execution side.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

FILE: design/lecn_front.sv
// Front end: accepts requests, classifies the opcode and queues the command.
// Depends on lecn_pkg.
module lecn_front import lecn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [2:0]           in_opcode,
  input  logic [PORT_BITS-1:0] in_arrival_port,
  input  logic [LVL_BITS-1:0]  in_cand_level,
  input  logic [ID_BITS-1:0]   in_cand_id,
  input  logic [PORT_BITS-1:0] in_relay_port,
  output cmd_chan_t            cmd_out,
  input  logic                 cmd_pop
);

  cmd_t                q_mem_r [CMD_Q_DEPTH];
  logic [CMD_Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_Q_AW:0]   cnt_r, cnt_nxt;
  logic                push_ok;
  cmd_t                cmd_dec;

  always_comb begin
    cmd_dec.arrival_port = in_arrival_port;
    cmd_dec.cand_level   = in_cand_level;
    cmd_dec.cand_id      = in_cand_id;
    cmd_dec.relay_port   = in_relay_port;
    case (in_opcode)
      OP_START:   cmd_dec.kind = CMD_START;
      OP_CAPTURE: cmd_dec.kind = CMD_CAPTURE;
      OP_ACCEPT:  cmd_dec.kind = CMD_ACCEPT;
      OP_HELP:    cmd_dec.kind = CMD_HELP;
      OP_DEFEAT:  cmd_dec.kind = CMD_DEFEAT;
      default:    cmd_dec.kind = CMD_NOP;
    endcase
  end

  assign in_full = (cnt_r == (CMD_Q_AW+1)'(CMD_Q_DEPTH));
  assign push_ok = in_push && !in_full;

  assign cmd_out.valid = (cnt_r != '0);
  assign cmd_out.cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CMD_Q_AW+1)'(push_ok) - (CMD_Q_AW+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= cmd_dec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (CMD_Q_AW+1)'(CMD_Q_DEPTH))
    else $error("command queue count overflow");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cnt_r != '0)
    else $error("command popped from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == rd_ptr_r + cnt_r[CMD_Q_AW-1:0])
    else $error("command queue pointers disagree with count");

endmodule

FILE: design/lecn_back.sv
// Back end: node state, configuration registers, message execution and
// the result queue. Depends on lecn_pkg.
module lecn_back import lecn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ID_BITS-1:0]   cfg_wdata,
  input  cmd_chan_t            cmd_in,
  output logic                 cmd_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output res_t                 res_out
);

  logic [ID_BITS-1:0]   node_id_r;
  logic [PORT_BITS-1:0] nbr_cnt_r;

  logic [1:0]           mode_r, mode_nxt;
  logic [LVL_BITS-1:0]  level_r, level_nxt;
  logic [PORT_BITS-1:0] parent_port_r, parent_port_nxt;
  logic                 leader_r, leader_nxt;

  res_t                 oq_mem_r [OUT_Q_DEPTH];
  logic                 oq_wr_r, oq_rd_r;
  logic [1:0]           oq_cnt_r, oq_cnt_nxt;
  logic                 oq_pop_ok;

  logic [PORT_BITS-1:0] ports;
  logic [LVL_BITS-1:0]  lvl_inc;
  logic                 stronger, weaker;
  cmd_t                 cmd;
  res_t                 res;

  assign cmd       = cmd_in.cmd;
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop_ok = out_pop && !out_empty;
  // A command executes when the result queue has a free slot this cycle.
  assign cmd_pop   = cmd_in.valid && ((oq_cnt_r != 2'(OUT_Q_DEPTH)) || oq_pop_ok);
  assign res_out   = oq_mem_r[oq_rd_r];

  assign ports = (nbr_cnt_r > PORT_BITS'(MAX_PORTS)) ? PORT_BITS'(MAX_PORTS) : nbr_cnt_r;
  assign lvl_inc = level_r + 1'b1;
  assign stronger = (cmd.cand_level > level_r) ||
                    ((cmd.cand_level == level_r) && (cmd.cand_id > node_id_r));
  assign weaker   = (cmd.cand_level < level_r) ||
                    ((cmd.cand_level == level_r) && (cmd.cand_id < node_id_r));

  always_comb begin
    mode_nxt        = mode_r;
    level_nxt       = level_r;
    parent_port_nxt = parent_port_r;
    leader_nxt      = leader_r;
    res             = '0;
    case (cmd.kind)
      CMD_START: begin
        mode_nxt        = MODE_CANDIDATE;
        level_nxt       = '0;
        parent_port_nxt = '0;
        leader_nxt      = 1'b0;
        res.send_valid  = 1'b1;
        res.send_kind   = KIND_CAPTURE;
        res.send_id     = node_id_r;
      end
      CMD_CAPTURE: begin
        if (mode_r != MODE_CAPTURED && stronger) begin
          mode_nxt        = MODE_CAPTURED;
          parent_port_nxt = cmd.arrival_port;
          leader_nxt      = 1'b0;
          res.send_valid  = 1'b1;
          res.send_port   = cmd.arrival_port;
          res.send_kind   = KIND_ACCEPT;
        end else if (mode_r == MODE_CAPTURED) begin
          res.send_valid = 1'b1;
          res.send_port  = parent_port_r;
          res.send_kind  = KIND_HELP;
          res.send_level = cmd.cand_level;
          res.send_id    = cmd.cand_id;
          res.send_relay = cmd.arrival_port;
        end
      end
      CMD_ACCEPT: begin
        if (mode_r == MODE_CANDIDATE && level_r < ports) begin
          level_nxt = lvl_inc;
          if (lvl_inc == ports) begin
            leader_nxt = 1'b1;
          end else begin
            res.send_valid = 1'b1;
            res.send_port  = lvl_inc;
            res.send_kind  = KIND_CAPTURE;
            res.send_level = lvl_inc;
            res.send_id    = node_id_r;
          end
        end
      end
      CMD_HELP: begin
        res.send_valid = 1'b1;
        res.send_port  = cmd.arrival_port;
        if (weaker) begin
          res.send_kind = KIND_VICTORY;
        end else begin
          if (mode_r == MODE_CANDIDATE) begin
            mode_nxt = MODE_PASSIVE;
          end
          res.send_kind  = KIND_DEFEAT;
          res.send_id    = cmd.cand_id;
          res.send_relay = cmd.relay_port;
        end
      end
      CMD_DEFEAT: begin
        parent_port_nxt = cmd.relay_port;
        res.send_valid  = 1'b1;
        res.send_port   = cmd.relay_port;
        res.send_kind   = KIND_ACCEPT;
      end
      default: begin
      end
    endcase
    res.node_mode = mode_nxt;
    res.is_leader = leader_nxt;
  end

  always_comb begin
    oq_cnt_nxt = oq_cnt_r + 2'(cmd_pop) - 2'(oq_pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r     <= '0;
      nbr_cnt_r     <= PORT_BITS'(1);
      mode_r        <= MODE_CANDIDATE;
      level_r       <= '0;
      parent_port_r <= '0;
      leader_r      <= 1'b0;
      oq_wr_r       <= 1'b0;
      oq_rd_r       <= 1'b0;
      oq_cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_ID:         node_id_r <= cfg_wdata;
          REG_NEIGHBOUR_COUNT: nbr_cnt_r <= cfg_wdata[PORT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_pop) begin
        mode_r        <= mode_nxt;
        level_r       <= level_nxt;
        parent_port_r <= parent_port_nxt;
        leader_r      <= leader_nxt;
        oq_wr_r       <= ~oq_wr_r;
      end
      if (oq_pop_ok) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'(OUT_Q_DEPTH))
    else $error("result queue count overflow");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.kind == CMD_START |=>
      level_r == '0 && mode_r == MODE_CANDIDATE && !leader_r)
    else $error("start did not return the node to its initial state");

  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> oq_mem_r[$past(oq_wr_r)].node_mode == mode_r &&
                oq_mem_r[$past(oq_wr_r)].is_leader == leader_r)
    else $error("queued status differs from node state");

  a_accept_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.kind == CMD_ACCEPT && mode_r == MODE_CANDIDATE && level_r < ports
      |=> level_r == $past(level_r) + 1'b1)
    else $error("accepted capture did not raise the level");

endmodule

FILE: design/leader_election_capture_node_top.sv
// A request is stored in the command queue, then executed into the result queue.
// Throughput: one request per cycle while the result queue has room or is popped; a
// 4-entry command queue and a 2-entry result queue let input and output stall
// independently. The execute step (compare, increment, state update) sets the rate.
// Reset (synchronous, rst_n low) empties both queues, returns the node to
// candidate at level 0 and sets node_id to 0 and neighbour_count to 1.
module leader_election_capture_node_top import lecn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ID_BITS-1:0]   cfg_wdata,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           in_opcode,
  input  logic [PORT_BITS-1:0] in_arrival_port,
  input  logic [LVL_BITS-1:0]  in_cand_level,
  input  logic [ID_BITS-1:0]   in_cand_id,
  input  logic [PORT_BITS-1:0] in_relay_port,
  output logic                 empty,
  input  logic                 pop,
  output logic                 out_send_valid,
  output logic [PORT_BITS-1:0] out_send_port,
  output logic [2:0]           out_send_kind,
  output logic [LVL_BITS-1:0]  out_send_level,
  output logic [ID_BITS-1:0]   out_send_id,
  output logic [PORT_BITS-1:0] out_send_relay,
  output logic [1:0]           out_node_mode,
  output logic                 out_is_leader
);

  cmd_chan_t cmd_chan;
  logic      cmd_pop;
  res_t      res;

  lecn_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .in_full         (full),
    .in_opcode       (in_opcode),
    .in_arrival_port (in_arrival_port),
    .in_cand_level   (in_cand_level),
    .in_cand_id      (in_cand_id),
    .in_relay_port   (in_relay_port),
    .cmd_out         (cmd_chan),
    .cmd_pop         (cmd_pop)
  );

  lecn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_in    (cmd_chan),
    .cmd_pop   (cmd_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .res_out   (res)
  );

  assign out_send_valid = res.send_valid;
  assign out_send_port  = res.send_port;
  assign out_send_kind  = res.send_kind;
  assign out_send_level = res.send_level;
  assign out_send_id    = res.send_id;
  assign out_send_relay = res.send_relay;
  assign out_node_mode  = res.node_mode;
  assign out_is_leader  = res.is_leader;

endmodule
